// ===== hdl/tgarle_pkg.sv =====
// tgarle_pkg: shared codes, sizes and helpers for the targa run-length pixel decoder
// no dependencies; imported by tga_rle_pixel_decoder and tgarle_checker
package tgarle_pkg;

   // palette store size and its address width
   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

   typedef logic [1:0] cmd_type;
   typedef logic [1:0] status_type;
   typedef logic [1:0] kind_type;
   typedef logic [2:0] csr_index_type;

   // input transaction kinds
   localparam cmd_type CMD_LOAD  = 2'd0;
   localparam cmd_type CMD_START = 2'd1;
   localparam cmd_type CMD_DATA  = 2'd2;
   localparam cmd_type CMD_END   = 2'd3;

   // result status codes
   localparam status_type STATUS_PIXEL     = 2'd0;
   localparam status_type STATUS_COMPLETE  = 2'd1;
   localparam status_type STATUS_OVERRUN   = 2'd2;
   localparam status_type STATUS_TRUNCATED = 2'd3;

   // image kinds; anything else decodes as true colour
   localparam kind_type KIND_PALETTE = 2'd0;
   localparam kind_type KIND_GREY    = 2'd1;

   // configuration register indexes
   localparam csr_index_type CSR_IMAGE_KIND      = 3'd0;
   localparam csr_index_type CSR_RLE_ENABLE      = 3'd1;
   localparam csr_index_type CSR_BYTES_PER_PIXEL = 3'd2;
   localparam csr_index_type CSR_ALPHA_BITS      = 3'd3;
   localparam csr_index_type CSR_PIXEL_TOTAL     = 3'd4;
   localparam csr_index_type CSR_PALETTE_LENGTH  = 3'd5;

   // 5-bit channel to 8 bits by replicating the top bits
   function automatic logic [7:0] expand5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

endpackage

// ===== hdl/tga_rle_pixel_decoder.sv =====
// tga_rle_pixel_decoder: targa image data decoder with run-length packets, top level
// depends on tgarle_pkg; palette store is an internal memory
//
// usage
//   req channel: one transaction per command; tuser holds the command (load palette
//   entry, start image, data byte, end of data), tdata the entry index, entry colour
//   and data byte. rsp channel: at most one transaction per request; tdata holds the
//   32-bit argb pixel and its repeat count, tuser the status, tlast marks the end of
//   the image. csr port: single-cycle register writes while the block is idle.
//   pipeline: two register stages; an accepted request goes into the palette read and
//   the stage register, and is decoded into the result register when the stage moves
//   on (result register free or being emptied), from where it can leave.
//   throughput: one request per cycle while the receiver does not stall, set by the
//   single decode stage; a run-length repeat packet leaves as one result with its count.
//   reset: synchronous; clears the palette (through per-entry valid bits, no sweep),
//   restores register defaults and leaves the decoder stopped until a start.
//   stall: while rsp_tready is low the result register holds; one more request may
//   sit in the stage register, after which req_tready drops until the result leaves.
//
module tga_rle_pixel_decoder
   import tgarle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // entry_index[7:0], entry_color[31:8], data_byte[39:32]
   input  logic [1:0]  req_tuser,   // command[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // pixel_argb[31:0], repeat_count[39:32]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast,
   // configuration write port
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // decode phase codes
   localparam logic PHASE_HEADER = 1'b0;
   localparam logic PHASE_PIXEL  = 1'b1;

   // configuration registers
   logic [1:0]  image_kind_ff;
   logic        rle_enable_ff;
   logic [2:0]  bytes_per_pixel_ff;
   logic [3:0]  alpha_bit_count_ff;
   logic [31:0] pixel_total_ff;
   logic [8:0]  palette_length_ff;

   // request fields
   cmd_type     in_cmd;
   logic [7:0]  in_index;
   logic [23:0] in_color;
   logic [7:0]  in_byte;
   logic        req_accept;
   logic        pal_wr;

   // palette store and its registered read port
   logic [23:0] palette_mem [PALETTE_DEPTH];
   logic        pal_valid_ff [PALETTE_DEPTH];
   logic [23:0] pal_rd_data_ff;
   logic        pal_rd_hit_ff;

   // stage register
   logic        s1_valid_ff;
   cmd_type     s1_cmd_ff;
   logic [7:0]  s1_index_ff;
   logic [23:0] s1_color_ff;
   logic [7:0]  s1_byte_ff;
   logic        advance;
   logic        fire;

   // decoder state
   logic        phase_ff, phase_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic        repeat_ff, repeat_in;
   logic [1:0]  byte_pos_ff, byte_pos_in;
   logic [23:0] pixel_bytes_ff, pixel_bytes_in;
   logic [31:0] pixels_left_ff, pixels_left_in;
   logic        stopped_ff, stopped_in;
   // palette lookup of the first byte of a multi-byte pixel
   logic [23:0] first_color_ff, first_color_in;
   logic        first_hit_ff, first_hit_in;

   // result register
   logic        out_valid_ff;
   logic [31:0] out_argb_ff;
   logic [7:0]  out_rep_ff;
   status_type  out_status_ff;
   logic        out_last_ff;

   // decode results
   logic        res_valid;
   logic [31:0] res_argb;
   logic [7:0]  res_rep;
   status_type  res_status;
   logic        res_last;

   // decode intermediates
   logic [2:0]  n_bytes;
   logic [2:0]  pos_p1;
   logic [23:0] bytes_new;
   logic [7:0]  b0;
   logic [23:0] pal_color;
   logic        pal_in_range;
   logic [3:0]  alpha_k;
   logic [15:0] alpha_shift;
   logic [7:0]  alpha;
   logic [31:0] argb;
   logic [7:0]  count;
   logic [7:0]  rep;
   logic [7:0]  pl_next;

   assign in_cmd   = req_tuser;
   assign in_index = req_tdata[7:0];
   assign in_color = req_tdata[31:8];
   assign in_byte  = req_tdata[39:32];

   // the stage moves on when the result register is free or being emptied
   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign pal_wr = req_accept && (in_cmd == CMD_LOAD) &&
                   ({1'b0, in_index} < 9'(PALETTE_DEPTH));

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_kind_ff      <= 2'd2;
         rle_enable_ff      <= 1'b0;
         bytes_per_pixel_ff <= 3'd3;
         alpha_bit_count_ff <= 4'd0;
         pixel_total_ff     <= 32'd1;
         palette_length_ff  <= 9'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_KIND:      image_kind_ff      <= csr_wdata[1:0];
            CSR_RLE_ENABLE:      rle_enable_ff      <= csr_wdata[0];
            CSR_BYTES_PER_PIXEL: bytes_per_pixel_ff <= csr_wdata[2:0];
            CSR_ALPHA_BITS:      alpha_bit_count_ff <= csr_wdata[3:0];
            CSR_PIXEL_TOTAL:     pixel_total_ff     <= csr_wdata;
            CSR_PALETTE_LENGTH:  palette_length_ff  <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // palette memory: write on load, read at the data byte of every accepted request
   always_ff @(posedge clock) begin
      if (pal_wr) begin
         palette_mem[in_index[PAL_AW-1:0]] <= in_color;
      end
      if (req_accept) begin
         pal_rd_data_ff <= palette_mem[in_byte[PAL_AW-1:0]];
      end
   end

   // entry valid bits stand in for clearing the store at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PALETTE_DEPTH; i++) begin
            pal_valid_ff[i] <= 1'b0;
         end
         pal_rd_hit_ff <= 1'b0;
      end else begin
         if (pal_wr) begin
            pal_valid_ff[in_index[PAL_AW-1:0]] <= 1'b1;
         end
         if (req_accept) begin
            pal_rd_hit_ff <= pal_valid_ff[in_byte[PAL_AW-1:0]];
         end
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff   <= in_cmd;
         s1_index_ff <= in_index;
         s1_color_ff <= in_color;
         s1_byte_ff  <= in_byte;
      end
   end

   // pixel assembly and conversion
   always_comb begin
      if (image_kind_ff == KIND_PALETTE || image_kind_ff == KIND_GREY) begin
         n_bytes = 3'd1;
      end else if (bytes_per_pixel_ff < 3'd2) begin
         n_bytes = 3'd2;
      end else if (bytes_per_pixel_ff > 3'd4) begin
         n_bytes = 3'd4;
      end else begin
         n_bytes = bytes_per_pixel_ff;
      end

      pos_p1 = {1'b0, byte_pos_ff} + 3'd1;
      if (byte_pos_ff != 2'd3) begin
         bytes_new = pixel_bytes_ff | (24'(s1_byte_ff) << {byte_pos_ff, 3'b000});
      end else begin
         bytes_new = pixel_bytes_ff;
      end
      b0 = bytes_new[7:0];

      // first byte of the pixel: this request's lookup, else the one saved earlier
      if (byte_pos_ff == 2'd0) begin
         pal_color = pal_rd_hit_ff ? pal_rd_data_ff : 24'd0;
      end else begin
         pal_color = first_hit_ff ? first_color_ff : 24'd0;
      end
      pal_in_range = ({1'b0, b0} < palette_length_ff) &&
                     ({1'b0, b0} < 9'(PALETTE_DEPTH));

      // alpha of 4-byte pixels, bit count saturating at 8
      alpha_k     = (alpha_bit_count_ff > 4'd8) ? 4'd8 : alpha_bit_count_ff;
      alpha_shift = 16'(s1_byte_ff) << (4'd8 - alpha_k);
      alpha       = (alpha_k == 4'd0) ? 8'hff : alpha_shift[7:0];

      if (image_kind_ff == KIND_PALETTE) begin
         argb = pal_in_range ? {8'hff, pal_color} : 32'hff00_0000;
      end else if (image_kind_ff == KIND_GREY) begin
         argb = {8'hff, b0, b0, b0};
      end else if (n_bytes == 3'd2) begin
         argb = {8'hff, expand5(bytes_new[14:10]), expand5(bytes_new[9:5]),
                 expand5(bytes_new[4:0])};
      end else if (n_bytes == 3'd3) begin
         argb = {8'hff, bytes_new};
      end else begin
         argb = {alpha, bytes_new};
      end

      count = {1'b0, s1_byte_ff[6:0]} + 8'd1;

      // run-length accounting for a finished pixel
      if (rle_enable_ff && repeat_ff) begin
         rep     = packet_left_ff;
         pl_next = 8'd0;
      end else begin
         rep     = 8'd1;
         pl_next = rle_enable_ff ? packet_left_ff - 8'd1 : packet_left_ff;
      end
   end

   // request decode
   always_comb begin
      phase_in       = phase_ff;
      packet_left_in = packet_left_ff;
      repeat_in      = repeat_ff;
      byte_pos_in    = byte_pos_ff;
      pixel_bytes_in = pixel_bytes_ff;
      pixels_left_in = pixels_left_ff;
      stopped_in     = stopped_ff;
      first_color_in = first_color_ff;
      first_hit_in   = first_hit_ff;
      res_valid      = 1'b0;
      res_argb       = 32'd0;
      res_rep        = 8'd0;
      res_status     = STATUS_PIXEL;
      res_last       = 1'b0;

      if (fire) begin
         unique case (s1_cmd_ff)
            CMD_LOAD: begin
               // keep the saved first-byte lookup current
               if ({1'b0, s1_index_ff} < 9'(PALETTE_DEPTH) &&
                   s1_index_ff == pixel_bytes_ff[7:0]) begin
                  first_color_in = s1_color_ff;
                  first_hit_in   = 1'b1;
               end
            end
            CMD_START: begin
               pixels_left_in = pixel_total_ff;
               packet_left_in = 8'd0;
               repeat_in      = 1'b0;
               byte_pos_in    = 2'd0;
               pixel_bytes_in = 24'd0;
               phase_in       = rle_enable_ff ? PHASE_HEADER : PHASE_PIXEL;
               if (pixel_total_ff == 32'd0) begin
                  stopped_in = 1'b1;
                  res_valid  = 1'b1;
                  res_status = STATUS_COMPLETE;
                  res_last   = 1'b1;
               end else begin
                  stopped_in = 1'b0;
               end
            end
            CMD_END: begin
               if (!stopped_ff) begin
                  stopped_in = 1'b1;
                  res_valid  = 1'b1;
                  res_status = STATUS_TRUNCATED;
                  res_last   = 1'b1;
               end
            end
            CMD_DATA: begin
               if (!stopped_ff) begin
                  if (rle_enable_ff && phase_ff == PHASE_HEADER) begin
                     // packet header
                     if ({24'd0, count} > pixels_left_ff) begin
                        stopped_in = 1'b1;
                        res_valid  = 1'b1;
                        res_status = STATUS_OVERRUN;
                        res_last   = 1'b1;
                     end else begin
                        packet_left_in = count;
                        repeat_in      = s1_byte_ff[7];
                        phase_in       = PHASE_PIXEL;
                        byte_pos_in    = 2'd0;
                        pixel_bytes_in = 24'd0;
                     end
                  end else begin
                     if (byte_pos_ff == 2'd0) begin
                        first_color_in = pal_rd_data_ff;
                        first_hit_in   = pal_rd_hit_ff;
                     end
                     if (pos_p1 < n_bytes) begin
                        byte_pos_in    = pos_p1[1:0];
                        pixel_bytes_in = bytes_new;
                     end else begin
                        byte_pos_in    = 2'd0;
                        pixel_bytes_in = 24'd0;
                        if (rle_enable_ff) begin
                           packet_left_in = pl_next;
                           if (pl_next == 8'd0) begin
                              phase_in = PHASE_HEADER;
                           end
                        end
                        pixels_left_in = ({24'd0, rep} >= pixels_left_ff) ?
                                         32'd0 : pixels_left_ff - {24'd0, rep};
                        res_valid = 1'b1;
                        res_argb  = argb;
                        res_rep   = rep;
                        if (pixels_left_in == 32'd0) begin
                           stopped_in = 1'b1;
                           res_last   = 1'b1;
                        end
                     end
                  end
               end
            end
         endcase
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_HEADER;
         packet_left_ff <= 8'd0;
         repeat_ff      <= 1'b0;
         byte_pos_ff    <= 2'd0;
         pixel_bytes_ff <= 24'd0;
         pixels_left_ff <= 32'd0;
         stopped_ff     <= 1'b1;
         first_hit_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         packet_left_ff <= packet_left_in;
         repeat_ff      <= repeat_in;
         byte_pos_ff    <= byte_pos_in;
         pixel_bytes_ff <= pixel_bytes_in;
         pixels_left_ff <= pixels_left_in;
         stopped_ff     <= stopped_in;
         first_hit_ff   <= first_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      first_color_ff <= first_color_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_argb_ff   <= res_argb;
         out_rep_ff    <= res_rep;
         out_status_ff <= res_status;
         out_last_ff   <= res_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_rep_ff, out_argb_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== hdl/tgarle_checker.sv =====
// tgarle_assertions: port-level assertions for the targa run-length pixel decoder
// depends on tgarle_pkg; bound to tga_rle_pixel_decoder below
module tgarle_assertions
   import tgarle_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // nothing comes out straight after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // every non-pixel status closes the image
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_PIXEL |-> rsp_tlast)
      else $error("status transaction without tlast");

   // a non-pixel status carries no pixel and no count
   a_status_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_PIXEL |-> rsp_tdata == 40'd0)
      else $error("status transaction with pixel payload");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

endmodule

bind tga_rle_pixel_decoder tgarle_assertions u_tgarle_assertions (.*);

// ===== verif/tgarle_checker.sv =====
`timescale 1ns / 1ps
// tgarle_checker: watches the request, result and register ports of the targa decoder
// and predicts every result, comparing field by field; depends on tgarle_pkg

module tgarle_checker
   import tgarle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // entry_index[7:0], entry_color[31:8], data_byte[39:32]
   input  logic [1:0]  req_tuser,   // command[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // pixel_argb[31:0], repeat_count[39:32]
   input  logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          failures,
   output int          outstanding
);

   localparam kind_type RESET_KIND = 2'd2;   // true colour

   typedef struct packed {
      logic [31:0] argb;
      logic [7:0]  repeat_count;
      status_type  status;
      logic        last;
   } pixel_result;

   // register copies
   kind_type    img_kind;
   logic        rle_on;
   logic [2:0]  stored_bpp;
   logic [3:0]  alpha_bits;
   logic [31:0] image_pixels;
   logic [8:0]  palette_len;

   // decoder state
   logic [23:0] palette [PALETTE_DEPTH];
   logic        in_header;
   logic [7:0]  packet_left;
   logic        repeat_pkt;
   logic [1:0]  byte_pos;
   logic [23:0] pixel_bytes;
   logic [31:0] pixels_left;
   logic        stopped;

   pixel_result expected_pixels [$];
   int          fail_count = 0;

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   function automatic logic [7:0] widen5(input logic [4:0] c);
      return (8'(c) << 3) | (8'(c) >> 2);
   endfunction

   function automatic logic [31:0] to_argb(input logic [23:0] bytes, input logic [7:0] fourth,
                                          input int nbytes);
      logic [7:0] b0;
      logic [7:0] alpha;
      int         k;
      b0 = bytes[7:0];
      if (img_kind == KIND_PALETTE) begin
         if ({1'b0, b0} >= palette_len || int'(b0) >= PALETTE_DEPTH) return 32'hff00_0000;
         return {8'hff, palette[b0]};
      end
      if (img_kind == KIND_GREY) return {8'hff, b0, b0, b0};
      if (nbytes == 2) return {8'hff, widen5(bytes[14:10]), widen5(bytes[9:5]), widen5(bytes[4:0])};
      if (nbytes == 3) return {8'hff, bytes};
      // only four-byte pixels carry alpha, left aligned by the alpha bit count
      alpha = 8'hff;
      k = alpha_bits;
      if (k != 0) begin
         if (k > 8) k = 8;
         alpha = 8'(fourth << (8 - k));
      end
      return {alpha, bytes};
   endfunction

   // advances the decoder by one request; returns 1 when it produces a result
   function automatic bit decode_request(input cmd_type cmd, input logic [7:0] idx,
                                         input logic [23:0] col, input logic [7:0] db,
                                         output pixel_result res);
      int          nbytes;
      logic [7:0]  count;
      logic [7:0]  rep;
      logic [31:0] argb;
      res = '0;
      if (cmd == CMD_LOAD) begin
         palette[idx] = col;
         return 1'b0;
      end
      if (cmd == CMD_START) begin
         pixels_left = image_pixels;
         packet_left = '0;
         repeat_pkt  = 1'b0;
         byte_pos    = '0;
         pixel_bytes = '0;
         in_header   = rle_on;
         if (pixels_left == 0) begin
            stopped    = 1'b1;
            res.status = STATUS_COMPLETE;
            res.last   = 1'b1;
            return 1'b1;
         end
         stopped = 1'b0;
         return 1'b0;
      end
      if (cmd == CMD_END) begin
         if (stopped) return 1'b0;
         stopped    = 1'b1;
         res.status = STATUS_TRUNCATED;
         res.last   = 1'b1;
         return 1'b1;
      end
      if (stopped) return 1'b0;

      if (rle_on && in_header) begin
         count = {1'b0, db[6:0]} + 8'd1;
         if (32'(count) > pixels_left) begin
            stopped    = 1'b1;
            res.status = STATUS_OVERRUN;
            res.last   = 1'b1;
            return 1'b1;
         end
         packet_left = count;
         repeat_pkt  = db[7];
         in_header   = 1'b0;
         byte_pos    = '0;
         pixel_bytes = '0;
         return 1'b0;
      end

      if (img_kind == KIND_PALETTE || img_kind == KIND_GREY) nbytes = 1;
      else if (stored_bpp < 3'd2) nbytes = 2;
      else if (stored_bpp > 3'd4) nbytes = 4;
      else nbytes = stored_bpp;

      if (byte_pos < 2'd3) pixel_bytes = pixel_bytes | (24'(db) << (8 * byte_pos));
      if (int'(byte_pos) + 1 < nbytes) begin
         byte_pos = byte_pos + 2'd1;
         return 1'b0;
      end
      argb        = to_argb(pixel_bytes, db, nbytes);
      byte_pos    = '0;
      pixel_bytes = '0;
      if (rle_on) begin
         if (repeat_pkt) begin
            rep         = packet_left;
            packet_left = '0;
         end else begin
            rep         = 8'd1;
            packet_left = packet_left - 8'd1;
         end
         if (packet_left == 0) in_header = 1'b1;
      end else begin
         rep = 8'd1;
      end
      pixels_left      = (32'(rep) >= pixels_left) ? 32'd0 : pixels_left - 32'(rep);
      res.argb         = argb;
      res.repeat_count = rep;
      res.status       = STATUS_PIXEL;
      res.last         = (pixels_left == 0);
      if (res.last) stopped = 1'b1;
      return 1'b1;
   endfunction

   task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
      $display("%0t tgarle_checker: %s expected %h actual %h", $time, name, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      pixel_result got, want, res;
      if (reset) begin
         img_kind     = RESET_KIND;
         rle_on       = 1'b0;
         stored_bpp   = 3'd3;
         alpha_bits   = '0;
         image_pixels = 32'd1;
         palette_len  = '0;
         for (int i = 0; i < PALETTE_DEPTH; i++) palette[i] = '0;
         in_header   = 1'b1;
         packet_left = '0;
         repeat_pkt  = 1'b0;
         byte_pos    = '0;
         pixel_bytes = '0;
         pixels_left = '0;
         stopped     = 1'b1;
         expected_pixels.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IMAGE_KIND:      img_kind     = csr_wdata[1:0];
               CSR_RLE_ENABLE:      rle_on       = csr_wdata[0];
               CSR_BYTES_PER_PIXEL: stored_bpp   = csr_wdata[2:0];
               CSR_ALPHA_BITS:      alpha_bits   = csr_wdata[3:0];
               CSR_PIXEL_TOTAL:     image_pixels = csr_wdata;
               CSR_PALETTE_LENGTH:  palette_len  = csr_wdata[8:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{argb: rsp_tdata[31:0], repeat_count: rsp_tdata[39:32],
                    status: rsp_tuser, last: rsp_tlast};
            if (expected_pixels.size() == 0) begin
               $display("%0t tgarle_checker: result with none expected, argb %h repeat %0d",
                        $time, got.argb, got.repeat_count);
               $display("%0t tgarle_checker: status %0d last %0d", $time, got.status, got.last);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (got.argb !== want.argb) report_field("pixel_argb", want.argb, got.argb);
               if (got.repeat_count !== want.repeat_count)
                  report_field("repeat_count", 32'(want.repeat_count), 32'(got.repeat_count));
               if (got.status !== want.status)
                  report_field("status", 32'(want.status), 32'(got.status));
               if (got.last !== want.last) report_field("last", 32'(want.last), 32'(got.last));
            end
         end
         if (req_tvalid && req_tready) begin
            if (decode_request(req_tuser, req_tdata[7:0], req_tdata[31:8], req_tdata[39:32], res))
               expected_pixels.push_back(res);
         end
      end
      outstanding <= expected_pixels.size();
      failures    <= fail_count;
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: clock, reset, request and register stimulus and the verdict for the
// targa run-length pixel decoder; depends on tgarle_pkg and tgarle_checker

module testbench;
   import tgarle_pkg::*;

   localparam int LATENCY     = 2;        // request to result, from the block's notes
   localparam int ITEM_QUOTA  = 750;      // random requests, spread over the idling phases
   localparam int CYCLE_LIMIT = 500000;
   localparam kind_type KIND_TRUE  = 2'd2;
   localparam kind_type KIND_SPARE = 2'd3; // undefined kind, decodes as true colour

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // entry_index[7:0], entry_color[31:8], data_byte[39:32]
   logic [1:0]  req_tuser  = '0;   // command[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // pixel_argb[31:0], repeat_count[39:32]
   logic [1:0]  rsp_tuser;         // status[1:0]
   logic        rsp_tlast;
   logic        csr_wr_en  = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [31:0] csr_wdata  = '0;

   int failures;
   int outstanding;
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int items_sent      = 0;
   int cycle_count     = 0;
   int directed_items;

   always #5 clock = ~clock;

   tga_rle_pixel_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tgarle_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // one request transaction, with a random gap ahead of it; fields that the
   // command does not use carry whatever the caller passes (mostly noise)
   task automatic issue(input cmd_type cmd, input logic [7:0] idx, input logic [23:0] col,
                        input logic [7:0] db);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {db, col, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_data(input logic [7:0] db);
      issue(CMD_DATA, 8'($urandom), 24'($urandom), db);
   endtask

   task automatic send_cmd(input cmd_type cmd);
      issue(cmd, 8'($urandom), 24'($urandom), 8'($urandom));
   endtask

   // random image byte; now and then a palette load slips in between
   task automatic pixel_byte();
      if ($urandom_range(39) == 0) send_cmd(CMD_LOAD);
      send_data(8'($urandom));
   endtask

   // wait until the block has nothing in flight, including requests that give no result
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // all six registers, written back to back while the block is idle
   task automatic configure(input kind_type kind, input logic rle, input logic [2:0] bpp,
                            input logic [3:0] abits, input logic [31:0] total,
                            input logic [8:0] plen);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IMAGE_KIND;      csr_wdata <= 32'(kind);  @(posedge clock);
      csr_index <= CSR_RLE_ENABLE;      csr_wdata <= 32'(rle);   @(posedge clock);
      csr_index <= CSR_BYTES_PER_PIXEL; csr_wdata <= 32'(bpp);   @(posedge clock);
      csr_index <= CSR_ALPHA_BITS;      csr_wdata <= 32'(abits); @(posedge clock);
      csr_index <= CSR_PIXEL_TOTAL;     csr_wdata <= total;      @(posedge clock);
      csr_index <= CSR_PALETTE_LENGTH;  csr_wdata <= 32'(plen);  @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // one random image: mostly well formed packets with random content, sometimes
   // cut short, overrun, restarted or followed by bytes the block should ignore
   task automatic run_image();
      kind_type    kind;
      logic        rle;
      logic [2:0]  bpp;
      logic [3:0]  abits;
      logic [31:0] total;
      logic [8:0]  plen;
      int          r, nb, goal, left, cnt, cap, room, saved;
      bit          rpt, cut, overrun;

      r = $urandom_range(9);
      kind  = (r < 3) ? KIND_PALETTE : (r < 5) ? KIND_GREY : (r < 9) ? KIND_TRUE : KIND_SPARE;
      rle   = $urandom_range(1);
      bpp   = ($urandom_range(9) < 8) ? 3'($urandom_range(4, 2)) : 3'($urandom_range(7));
      abits = ($urandom_range(3) != 0) ? 4'($urandom_range(8)) : 4'($urandom_range(15));
      case ($urandom_range(5))
         0:       plen = 9'd0;
         1:       plen = 9'd256;
         2:       plen = 9'h1ff;
         default: plen = 9'($urandom_range(300));
      endcase
      r = $urandom_range(19);
      if (r == 0) total = 32'd0;
      else if (r == 1) total = $urandom;
      else if (rle && r < 8) total = $urandom_range(400, 100);
      else total = $urandom_range(16, 1);

      // huge images are always cut short by an end transaction
      cut = (total != 0) && (total > 400 || $urandom_range(9) == 0);
      if (total > 400) goal = $urandom_range(30);
      else if (cut) goal = $urandom_range(int'(total) - 1);
      else goal = int'(total);

      if (kind == KIND_PALETTE || kind == KIND_GREY) nb = 1;
      else if (bpp < 3'd2) nb = 2;
      else if (bpp > 3'd4) nb = 4;
      else nb = bpp;

      configure(kind, rle, bpp, abits, total, plen);
      if (kind == KIND_PALETTE) repeat ($urandom_range(4)) send_cmd(CMD_LOAD);
      send_cmd(CMD_START);

      left    = goal;
      overrun = 1'b0;
      while (left > 0 && !overrun) begin
         if (rle) begin
            cap = (left < 128) ? left : 128;
            if (!cut && left < 128 && $urandom_range(24) == 0) begin
               // header asking for more pixels than remain
               send_data({1'($urandom_range(1)), 7'($urandom_range(127, left))});
               overrun = 1'b1;
            end else begin
               rpt = ($urandom_range(3) != 0);
               cnt = rpt ? $urandom_range(cap, 1) : $urandom_range((cap < 6) ? cap : 6, 1);
               send_data({rpt, 7'(cnt - 1)});
               repeat (rpt ? nb : cnt * nb) pixel_byte();
               left -= cnt;
            end
         end else begin
            repeat (nb) pixel_byte();
            left--;
         end
         // restart in the middle of the image, sometimes mid-pixel
         if (left > 0 && !overrun && $urandom_range(49) == 0) begin
            if (!rle) repeat ($urandom_range(nb - 1)) pixel_byte();
            send_cmd(CMD_START);
            left = goal;
         end
      end

      if (cut) begin
         if (rle && $urandom_range(1) == 1) begin
            room = (total - 32'(goal) > 32'd128) ? 128 : int'(total - 32'(goal));
            send_data({1'($urandom_range(1)), 7'($urandom_range(room, 1) - 1)});
            repeat ($urandom_range(nb - 1)) pixel_byte();
         end else if (!rle) begin
            repeat ($urandom_range(nb - 1)) pixel_byte();
         end
         send_cmd(CMD_END);
      end

      // stray bytes and ends while stopped; they do not count as stimulus
      if ($urandom_range(3) == 0) begin
         saved = items_sent;
         repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(1) == 0) send_data(8'($urandom));
            else send_cmd(CMD_END);
         end
         items_sent = saved;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: data and end before any start are ignored
      send_data(8'hff);
      send_cmd(CMD_END);

      // empty image completes at once
      configure(KIND_TRUE, 1'b0, 3'd3, 4'd0, 32'd0, 9'd0);
      send_cmd(CMD_START);

      // palette: loaded entry, entry beyond the loaded length, entry never loaded
      configure(KIND_PALETTE, 1'b0, 3'd3, 4'd0, 32'd3, 9'd2);
      issue(CMD_LOAD, 8'd1, 24'h123456, 8'($urandom));
      issue(CMD_LOAD, 8'hff, 24'hffffff, 8'($urandom));
      send_cmd(CMD_START);
      send_data(8'd1);
      send_data(8'hff);
      send_data(8'd0);

      // grey with packets: longest repeat, a literal pair, then a header that overruns
      configure(KIND_GREY, 1'b1, 3'd0, 4'd15, 32'd131, 9'h1ff);
      send_cmd(CMD_START);
      send_data(8'hff);
      send_data(8'hff);
      send_data(8'h01);
      send_data(8'h00);
      send_data(8'h80);
      send_data(8'h81);

      // 5-5-5 with an odd size register, all channels full, then an early end
      configure(KIND_TRUE, 1'b0, 3'd1, 4'd1, 32'd5, 9'd0);
      send_cmd(CMD_START);
      send_data(8'hff);
      send_data(8'h7f);
      send_cmd(CMD_END);

      // 32-bit pixel with all eight alpha bits, largest image, early end
      configure(KIND_TRUE, 1'b0, 3'd4, 4'd8, 32'hffff_ffff, 9'd256);
      send_cmd(CMD_START);
      send_data(8'h11);
      send_data(8'h22);
      send_data(8'h33);
      send_data(8'hc5);
      send_cmd(CMD_END);
      directed_items = items_sent;

      // random images under four idling phases: none, sender gaps,
      // receiver stalls, then a little of both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin sender_idle_pct = 56; rsp_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  rsp_stall_pct = 56; end
            default: begin sender_idle_pct = 16; rsp_stall_pct = 16; end
         endcase
         while (items_sent < directed_items + ITEM_QUOTA * (phase + 1) / 4) run_image();
      end

      drain();
      if (failures == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/tgarle_pkg.sv
hdl/tga_rle_pixel_decoder.sv
hdl/tgarle_checker.sv
verif/tgarle_checker.sv
verif/testbench.sv
